@@ rtl/dsched_pkg.sv @@
// ----------------------------------------------------------------------------
// dsched_pkg
// Shared types and constants of the disk request scheduler.
// ----------------------------------------------------------------------------
package dsched_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int BLOCK_BITS  = 16;
	localparam int TAG_W       = 8;
	localparam int AGE_W       = 8;
	localparam int POL_W       = 2;
	localparam int DISK_W      = BLOCK_BITS + 1;
	localparam int KEY_W       = BLOCK_BITS + 1;
	localparam int SUM_W       = 32;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISK_BLOCKS = 1'd1;

	localparam logic [POL_W-1:0] POL_FCFS  = 2'd0;
	localparam logic [POL_W-1:0] POL_SSTF  = 2'd1;
	localparam logic [POL_W-1:0] POL_CSCAN = 2'd2;

	localparam logic [DISK_W-1:0] DISK_BLOCKS_RST = 17'd256;

	typedef enum logic [2:0] {
		STAT_ENQUEUED   = 3'd0,
		STAT_DISPATCHED = 3'd1,
		STAT_FULL       = 3'd2,
		STAT_RANGE      = 3'd3,
		STAT_EMPTY      = 3'd4
	} status_t;

	typedef struct packed {
		logic [BLOCK_BITS-1:0] block;
		logic                  is_write;
		logic [TAG_W-1:0]      tag;
		logic [AGE_W-1:0]      stamp;
	} entry_t;

	typedef struct packed {
		logic             clear;
		logic             sample;
		logic [IDX_W-1:0] idx;
	} pick_ctl_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
		entry_t           ent;
	} pick_res_t;

	typedef struct packed {
		status_t               status;
		logic [BLOCK_BITS-1:0] grant_block;
		logic                  grant_is_write;
		logic [TAG_W-1:0]      grant_tag;
		logic [BLOCK_BITS-1:0] seek_distance;
		logic [SUM_W-1:0]      total_distance;
	} rsp_t;

endpackage

@@ rtl/dsched_req_if.sv @@
// ----------------------------------------------------------------------------
// dsched_req_if
// Request channel: enqueue or dispatch items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dsched_req_if;
	logic                              valid;
	logic                              ready;
	logic                              mode;
	logic [dsched_pkg::BLOCK_BITS-1:0] block;
	logic                              is_write;
	logic [dsched_pkg::TAG_W-1:0]      requester_tag;

	modport source (output valid, output mode, output block, output is_write,
		output requester_tag, input ready);
	modport sink (input valid, input mode, input block, input is_write,
		input requester_tag, output ready);
endinterface

@@ rtl/dsched_rsp_if.sv @@
// ----------------------------------------------------------------------------
// dsched_rsp_if
// Result channel: one result per request with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dsched_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [2:0]                        status;
	logic [dsched_pkg::BLOCK_BITS-1:0] grant_block;
	logic                              grant_is_write;
	logic [dsched_pkg::TAG_W-1:0]      grant_tag;
	logic [dsched_pkg::BLOCK_BITS-1:0] seek_distance;
	logic [dsched_pkg::SUM_W-1:0]      total_distance;

	modport source (output valid, output status, output grant_block,
		output grant_is_write, output grant_tag, output seek_distance,
		output total_distance, input ready);
	modport sink (input valid, input status, input grant_block,
		input grant_is_write, input grant_tag, input seek_distance,
		input total_distance, output ready);
endinterface

@@ rtl/dsched_store.sv @@
// ----------------------------------------------------------------------------
// dsched_store
// Entry RAM (block, flag, tag, arrival stamp) with registered read, plus
// per-entry valid bits and the lowest-free-slot encoder.
// ----------------------------------------------------------------------------
module dsched_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [dsched_pkg::IDX_W-1:0]  wr_idx,
	input  dsched_pkg::entry_t            wr_data,
	input  logic                          clr_en,
	input  logic [dsched_pkg::IDX_W-1:0]  clr_idx,
	input  logic [dsched_pkg::IDX_W-1:0]  rd_idx,
	output dsched_pkg::entry_t            rd_data,
	output logic [dsched_pkg::QUEUE_DEPTH-1:0] valid,
	output logic                          free_found,
	output logic [dsched_pkg::IDX_W-1:0]  free_idx
);

	dsched_pkg::entry_t entry_mem [dsched_pkg::QUEUE_DEPTH];
	dsched_pkg::entry_t rd_data_q;
	logic [dsched_pkg::QUEUE_DEPTH-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[wr_idx] <= wr_data;
		end
		rd_data_q <= entry_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (clr_en) begin
				valid_q[clr_idx] <= 1'b0;
			end
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
		end
	end

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = dsched_pkg::QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = dsched_pkg::IDX_W'(i);
			end
		end
	end

	assign rd_data = rd_data_q;
	assign valid   = valid_q;

endmodule

@@ rtl/dsched_pick.sv @@
// ----------------------------------------------------------------------------
// dsched_pick
// Running best-candidate compare over the entries streamed out of the RAM.
// Key per policy; ties go to the larger age, then the lower slot.
// ----------------------------------------------------------------------------
module dsched_pick (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dsched_pkg::pick_ctl_t             ctl,
	input  dsched_pkg::entry_t                ent,
	input  logic                              ent_valid,
	input  logic [dsched_pkg::POL_W-1:0]      policy,
	input  logic [dsched_pkg::BLOCK_BITS-1:0] head,
	input  logic [dsched_pkg::AGE_W-1:0]      arrival,
	output dsched_pkg::pick_res_t             res
);

	logic                            found_q;
	logic [dsched_pkg::IDX_W-1:0]    idx_q;
	dsched_pkg::entry_t              ent_q;
	logic [dsched_pkg::KEY_W-1:0]    key_q;
	logic [dsched_pkg::AGE_W-1:0]    age_q;

	logic                            below;
	logic [dsched_pkg::BLOCK_BITS-1:0] seek;
	logic [dsched_pkg::KEY_W-1:0]    key;
	logic [dsched_pkg::AGE_W-1:0]    age;
	logic                            better;

	always_comb begin
		below = ent.block < head;
		seek  = below ? (head - ent.block) : (ent.block - head);
		case (policy)
			dsched_pkg::POL_SSTF:  key = {1'b0, seek};
			dsched_pkg::POL_CSCAN: key = {below, ent.block};
			default:               key = '0;
		endcase
		age    = arrival - ent.stamp;
		better = !found_q || (key < key_q) || ((key == key_q) && (age > age_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (ctl.sample && ent_valid) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ctl.clear && ctl.sample && ent_valid && better) begin
			idx_q <= ctl.idx;
			ent_q <= ent;
			key_q <= key;
			age_q <= age;
		end
	end

	assign res = '{found: found_q, idx: idx_q, ent: ent_q};

	a_clear_drops: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |=> !found_q)
		else $error("candidate survives a clear");
	a_found_holds: assert property (@(posedge clk) disable iff (!arst_n)
		found_q && !ctl.clear |=> found_q)
		else $error("candidate lost during scan");
	a_key_mono: assert property (@(posedge clk) disable iff (!arst_n)
		found_q && !ctl.clear |=> key_q <= $past(key_q))
		else $error("best key grew during scan");

endmodule

@@ rtl/dsched_sched_ctl.sv @@
// ----------------------------------------------------------------------------
// dsched_sched_ctl
// Sequencer: enqueue write, dispatch scan, grant update and result register.
// ----------------------------------------------------------------------------
module dsched_sched_ctl (
	input  logic                               clk,
	input  logic                               arst_n,
	dsched_req_if.sink                         req,
	dsched_rsp_if.source                       rsp,
	input  logic [dsched_pkg::POL_W-1:0]       policy,
	input  logic [dsched_pkg::DISK_W-1:0]      disk_blocks
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_GRANT = 4'b0100,
		S_OUT   = 4'b1000
	} state_t;

	state_t                              st_q;
	logic [dsched_pkg::CNT_W-1:0]        cnt_q;
	logic                                rd_v_s1;
	logic [dsched_pkg::IDX_W-1:0]        rd_idx_s1;
	logic [dsched_pkg::AGE_W-1:0]        arrival_q;
	logic [dsched_pkg::BLOCK_BITS-1:0]   head_q;
	logic [dsched_pkg::SUM_W-1:0]        sum_q;
	dsched_pkg::rsp_t                    res_q;
	dsched_pkg::rsp_t                    out_q;
	logic                                out_v_q;

	logic                                acc;
	logic                                issue;
	logic                                enq_ok;
	logic                                range_bad;
	logic                                grant;
	logic [dsched_pkg::BLOCK_BITS-1:0]   gblk;
	logic [dsched_pkg::BLOCK_BITS-1:0]   seek;
	logic [dsched_pkg::SUM_W:0]          sum_ext;
	logic [dsched_pkg::SUM_W-1:0]        sum_nxt;
	logic                                out_load;
	dsched_pkg::rsp_t                    res_nxt;

	dsched_pkg::entry_t                  wr_data;
	dsched_pkg::entry_t                  rd_data;
	logic [dsched_pkg::QUEUE_DEPTH-1:0]  valid_vec;
	logic                                free_found;
	logic [dsched_pkg::IDX_W-1:0]        free_idx;
	dsched_pkg::pick_ctl_t               pick_ctl;
	dsched_pkg::pick_res_t               pick_res;

	assign acc       = req.valid && req.ready;
	assign issue     = (st_q == S_SCAN) && (cnt_q < dsched_pkg::CNT_W'(dsched_pkg::QUEUE_DEPTH));
	assign range_bad = {1'b0, req.block} >= disk_blocks;
	assign enq_ok    = acc && !req.mode && !range_bad && free_found;
	assign grant     = (st_q == S_GRANT) && pick_res.found;
	assign wr_data   = '{block: req.block, is_write: req.is_write,
		tag: req.requester_tag, stamp: arrival_q};

	assign gblk    = pick_res.ent.block;
	assign seek    = (gblk >= head_q) ? (gblk - head_q) : (head_q - gblk);
	assign sum_ext = {1'b0, sum_q} + (dsched_pkg::SUM_W + 1)'(seek);
	assign sum_nxt = sum_ext[dsched_pkg::SUM_W] ? '1 : sum_ext[dsched_pkg::SUM_W-1:0];

	assign pick_ctl = '{clear: acc && req.mode, sample: rd_v_s1, idx: rd_idx_s1};
	assign out_load = (st_q == S_OUT) && (!out_v_q || rsp.ready);

	dsched_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (enq_ok),
		.wr_idx     (free_idx),
		.wr_data    (wr_data),
		.clr_en     (grant),
		.clr_idx    (pick_res.idx),
		.rd_idx     (cnt_q[dsched_pkg::IDX_W-1:0]),
		.rd_data    (rd_data),
		.valid      (valid_vec),
		.free_found (free_found),
		.free_idx   (free_idx)
	);

	dsched_pick u_pick (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (pick_ctl),
		.ent       (rd_data),
		.ent_valid (valid_vec[rd_idx_s1]),
		.policy    (policy),
		.head      (head_q),
		.arrival   (arrival_q),
		.res       (pick_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			cnt_q     <= '0;
			rd_v_s1   <= 1'b0;
			arrival_q <= '0;
			head_q    <= '0;
			sum_q     <= '0;
			out_v_q   <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (enq_ok) begin
				arrival_q <= arrival_q + 1'b1;
			end
			if (grant) begin
				head_q <= gblk;
				sum_q  <= sum_nxt;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (acc) begin
						st_q <= req.mode ? S_SCAN : S_OUT;
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (!issue) begin
						st_q <= S_GRANT;
					end
				end
				S_GRANT: st_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		res_nxt                = '0;
		res_nxt.total_distance = sum_q;
		if (st_q == S_GRANT) begin
			if (pick_res.found) begin
				res_nxt.status         = dsched_pkg::STAT_DISPATCHED;
				res_nxt.grant_block    = gblk;
				res_nxt.grant_is_write = pick_res.ent.is_write;
				res_nxt.grant_tag      = pick_res.ent.tag;
				res_nxt.seek_distance  = seek;
				res_nxt.total_distance = sum_nxt;
			end else begin
				res_nxt.status = dsched_pkg::STAT_EMPTY;
			end
		end else if (range_bad) begin
			res_nxt.status = dsched_pkg::STAT_RANGE;
		end else if (!free_found) begin
			res_nxt.status = dsched_pkg::STAT_FULL;
		end else begin
			res_nxt.status = dsched_pkg::STAT_ENQUEUED;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[dsched_pkg::IDX_W-1:0];
		if ((acc && !req.mode) || (st_q == S_GRANT)) begin
			res_q <= res_nxt;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign req.ready          = (st_q == S_IDLE);
	assign rsp.valid          = out_v_q;
	assign rsp.status         = out_q.status;
	assign rsp.grant_block    = out_q.grant_block;
	assign rsp.grant_is_write = out_q.grant_is_write;
	assign rsp.grant_tag      = out_q.grant_tag;
	assign rsp.seek_distance  = out_q.seek_distance;
	assign rsp.total_distance = out_q.total_distance;

	a_grant_clears: assert property (@(posedge clk) disable iff (!arst_n)
		grant |=> !valid_vec[$past(pick_res.idx)])
		else $error("dispatched entry still valid");
	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_GRANT |-> $past(cnt_q) == dsched_pkg::CNT_W'(dsched_pkg::QUEUE_DEPTH))
		else $error("grant before scan finished");
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(st_q))
		else $error("state register not one-hot");

endmodule

@@ rtl/disk_request_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// disk_request_scheduler_core
// Disk request queue with FCFS, SSTF and C-SCAN dispatch; config registers.
// ----------------------------------------------------------------------------
// Enqueue: the status is registered at the request transfer, then loaded into the output register.
// Dispatch: the entry RAM is read one entry per cycle through its single read
//   port, then the best entry is granted and the result is registered.
// One item in flight: a new request is taken only after the previous result is loaded for output.
// Reset clears valid bits, head, total, arrival stamp; policy FCFS,
//   disk_blocks 256. The entry RAM itself is not cleared.
module disk_request_scheduler_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	dsched_req_if.sink                           req,
	dsched_rsp_if.source                         rsp,
	input  logic                                 cfg_we,
	input  logic [dsched_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dsched_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [dsched_pkg::POL_W-1:0]  policy_q;
	logic [dsched_pkg::DISK_W-1:0] disk_blocks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q      <= dsched_pkg::POL_FCFS;
			disk_blocks_q <= dsched_pkg::DISK_BLOCKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dsched_pkg::CFG_POLICY:      policy_q <= cfg_data[dsched_pkg::POL_W-1:0];
				dsched_pkg::CFG_DISK_BLOCKS: disk_blocks_q <= cfg_data[dsched_pkg::DISK_W-1:0];
				default: ;
			endcase
		end
	end

	dsched_sched_ctl u_ctl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.policy      (policy_q),
		.disk_blocks (disk_blocks_q)
	);

endmodule

@@ dv/tb_disk_request_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// tb_disk_request_scheduler_core
// Self-checking bench for the disk request scheduler. Enqueue and dispatch
// transfers are fed from a backlog queue with random gaps. Each accepted
// request is run through a cycle-free scheduler predictor (FCFS, SSTF and
// C-SCAN, arrival ages, head and total seek), and every result transfer is
// checked against the oldest prediction. A directed opening covers the empty,
// full and out-of-range paths. Random phases sweep the policy and disk-size
// settings, and one long phase makes an entry's arrival age wrap.
// ----------------------------------------------------------------------------
module tb_disk_request_scheduler_core;

	localparam logic       MODE_ENQ  = 1'b0;
	localparam logic       MODE_DISP = 1'b1;
	localparam logic [1:0] POL_ALIAS = 2'd3;
	localparam int         LIMIT     = 400000;
	localparam int         N_PHASES  = 10;

	typedef struct packed {
		logic                              mode;
		logic [dsched_pkg::BLOCK_BITS-1:0] block;
		logic                              is_write;
		logic [dsched_pkg::TAG_W-1:0]      tag;
	} req_item_t;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	logic [dsched_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [dsched_pkg::CFG_DATA_W-1:0] cfg_data;

	dsched_req_if req_ch ();
	dsched_rsp_if rsp_ch ();

	disk_request_scheduler_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// scheduler predictor state
	dsched_pkg::entry_t                slots    [dsched_pkg::QUEUE_DEPTH];
	bit                                occupied [dsched_pkg::QUEUE_DEPTH];
	logic [dsched_pkg::AGE_W-1:0]      arrivals   = '0;
	logic [dsched_pkg::BLOCK_BITS-1:0] head_pos   = '0;
	logic [dsched_pkg::SUM_W-1:0]      seek_total = '0;
	logic [dsched_pkg::POL_W-1:0]      pol_q      = dsched_pkg::POL_FCFS;
	logic [dsched_pkg::DISK_W-1:0]     disk_sz    = dsched_pkg::DISK_BLOCKS_RST;

	req_item_t        req_backlog [$];
	dsched_pkg::rsp_t rsp_due     [$];

	int  req_issued = 0;
	int  req_xfers  = 0;
	int  rsp_xfers  = 0;
	int  rsp_seen   = 0;
	int  req_gap    = 0;
	int  rsp_stall  = 0;
	int  errors     = 0;
	int  cycles     = 0;

	int ph_pol  [N_PHASES];
	int ph_disk [N_PHASES];

	function automatic logic [dsched_pkg::BLOCK_BITS-1:0] seek_of(
		logic [dsched_pkg::BLOCK_BITS-1:0] b);
		return (b >= head_pos) ? b - head_pos : head_pos - b;
	endfunction

	function automatic logic [dsched_pkg::AGE_W-1:0] age_of(int i);
		return arrivals - slots[i].stamp;
	endfunction

	function automatic int pick_request();
		int                                best;
		bit                                above;
		logic [dsched_pkg::BLOCK_BITS-1:0] kc;
		logic [dsched_pkg::BLOCK_BITS-1:0] kb;
		best  = -1;
		above = 0;
		if (pol_q == dsched_pkg::POL_CSCAN) begin
			for (int i = 0; i < dsched_pkg::QUEUE_DEPTH; i++)
				if (occupied[i] && slots[i].block >= head_pos)
					above = 1;
		end
		for (int i = 0; i < dsched_pkg::QUEUE_DEPTH; i++) begin
			if (!occupied[i])
				continue;
			if (pol_q == dsched_pkg::POL_CSCAN && above && slots[i].block < head_pos)
				continue;
			if (best < 0) begin
				best = i;
				continue;
			end
			case (pol_q)
				dsched_pkg::POL_SSTF: begin
					kc = seek_of(slots[i].block);
					kb = seek_of(slots[best].block);
				end
				dsched_pkg::POL_CSCAN: begin
					kc = slots[i].block;
					kb = slots[best].block;
				end
				default: begin
					kc = '0;
					kb = '0;
				end
			endcase
			if (kc < kb || (kc == kb && age_of(i) > age_of(best)))
				best = i;
		end
		return best;
	endfunction

	function automatic dsched_pkg::rsp_t sched_step(req_item_t it);
		dsched_pkg::rsp_t                  r;
		int                                slot;
		int                                c;
		logic [dsched_pkg::BLOCK_BITS-1:0] d;
		r    = '0;
		slot = -1;
		if (it.mode == MODE_ENQ) begin
			for (int i = 0; i < dsched_pkg::QUEUE_DEPTH; i++)
				if (!occupied[i] && slot < 0)
					slot = i;
			if ({1'b0, it.block} >= disk_sz) begin
				r.status = dsched_pkg::STAT_RANGE;
			end else if (slot < 0) begin
				r.status = dsched_pkg::STAT_FULL;
			end else begin
				slots[slot]    = '{block: it.block, is_write: it.is_write, tag: it.tag,
					stamp: arrivals};
				occupied[slot] = 1;
				arrivals       = arrivals + 1'b1;
				r.status       = dsched_pkg::STAT_ENQUEUED;
			end
		end else begin
			c = pick_request();
			if (c < 0) begin
				r.status = dsched_pkg::STAT_EMPTY;
			end else begin
				d                = seek_of(slots[c].block);
				r.status         = dsched_pkg::STAT_DISPATCHED;
				r.grant_block    = slots[c].block;
				r.grant_is_write = slots[c].is_write;
				r.grant_tag      = slots[c].tag;
				r.seek_distance  = d;
				if (33'(seek_total) + 33'(d) > 33'h0_FFFF_FFFF)
					seek_total = '1;
				else
					seek_total = seek_total + 32'(d);
				head_pos    = slots[c].block;
				occupied[c] = 0;
			end
		end
		r.total_distance = seek_total;
		return r;
	endfunction

	// mostly in-range blocks, clustered low and high for ties, some out of range
	function automatic logic [dsched_pkg::BLOCK_BITS-1:0] rand_block();
		int top;
		int w;
		int r;
		top = int'(disk_sz) - 1;
		w   = (top < 15) ? top : 15;
		r   = $urandom_range(0, 15);
		if (top < 0 || r == 0)
			return 16'($urandom);
		if (r == 1)
			return (top >= 65535) ? 16'hFFFF : 16'(top + $urandom_range(0, 1));
		if (r < 6)
			return 16'($urandom_range(0, w));
		if (r < 8)
			return 16'(top - $urandom_range(0, w));
		return 16'($urandom_range(0, top));
	endfunction

	task automatic push_enq(logic [dsched_pkg::BLOCK_BITS-1:0] blk, logic wr,
		logic [dsched_pkg::TAG_W-1:0] tag);
		req_backlog.push_back('{mode: MODE_ENQ, block: blk, is_write: wr, tag: tag});
	endtask

	task automatic push_disp();
		req_backlog.push_back('{mode: MODE_DISP, block: 16'($urandom),
			is_write: 1'($urandom), tag: 8'($urandom)});
	endtask

	task automatic write_reg(logic [dsched_pkg::CFG_IDX_W-1:0] idx,
		logic [dsched_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == dsched_pkg::CFG_POLICY)
			pol_q = val[dsched_pkg::POL_W-1:0];
		else
			disk_sz = val;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (req_backlog.size() != 0 || req_issued != req_xfers || rsp_due.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// request driver
	always @(negedge clk) begin
		req_item_t it;
		if (arst_n && req_issued == req_xfers) begin
			if (req_gap > 0) begin
				req_ch.valid <= 1'b0;
				req_gap--;
			end else if (req_backlog.size() != 0) begin
				it = req_backlog.pop_front();
				req_ch.valid         <= 1'b1;
				req_ch.mode          <= it.mode;
				req_ch.block         <= it.block;
				req_ch.is_write      <= it.is_write;
				req_ch.requester_tag <= it.tag;
				req_issued++;
				req_gap = $urandom_range(0, 7);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// result ready: stall counts down only while a result is offered
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_xfers != rsp_seen) begin
				rsp_seen  = rsp_xfers;
				rsp_stall = $urandom_range(0, 7);
			end
			rsp_ch.ready <= (rsp_stall == 0);
			if (rsp_ch.valid && rsp_stall > 0)
				rsp_stall--;
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		dsched_pkg::rsp_t got;
		dsched_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				rsp_xfers++;
				got = '{status: dsched_pkg::status_t'(rsp_ch.status),
					grant_block: rsp_ch.grant_block,
					grant_is_write: rsp_ch.grant_is_write, grant_tag: rsp_ch.grant_tag,
					seek_distance: rsp_ch.seek_distance,
					total_distance: rsp_ch.total_distance};
				if (rsp_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result transfer: status %0d block %0d",
							got.status, got.grant_block);
				end else begin
					want = rsp_due.pop_front();
					if (got.status !== want.status || got.grant_block !== want.grant_block ||
							got.grant_is_write !== want.grant_is_write ||
							got.grant_tag !== want.grant_tag ||
							got.seek_distance !== want.seek_distance ||
							got.total_distance !== want.total_distance) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch: exp st %0d blk %0d wr %0d tag %0d seek %0d tot %0d",
								want.status, want.grant_block, want.grant_is_write,
								want.grant_tag, want.seek_distance, want.total_distance);
							$display("          got st %0d blk %0d wr %0d tag %0d seek %0d tot %0d",
								got.status, got.grant_block, got.grant_is_write,
								got.grant_tag, got.seek_distance, got.total_distance);
						end
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				req_xfers++;
				rsp_due.push_back(sched_step('{mode: req_ch.mode, block: req_ch.block,
					is_write: req_ch.is_write, tag: req_ch.requester_tag}));
			end
		end
	end

	initial begin
		int enq_pct;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = '0;
		cfg_data             = '0;
		req_ch.valid         = 1'b0;
		req_ch.mode          = MODE_ENQ;
		req_ch.block         = '0;
		req_ch.is_write      = 1'b0;
		req_ch.requester_tag = '0;
		rsp_ch.ready         = 1'b0;
		for (int i = 0; i < dsched_pkg::QUEUE_DEPTH; i++)
			occupied[i] = 0;
		ph_pol  = '{dsched_pkg::POL_SSTF, dsched_pkg::POL_CSCAN, POL_ALIAS,
			dsched_pkg::POL_FCFS, dsched_pkg::POL_CSCAN, dsched_pkg::POL_SSTF,
			dsched_pkg::POL_FCFS, dsched_pkg::POL_CSCAN, dsched_pkg::POL_SSTF,
			dsched_pkg::POL_FCFS};
		ph_disk = '{16, 16, 256, 0, 65536, 65536, 1, 1000, 300, 65535};
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// directed, reset configuration
		push_disp();
		push_enq(16'd255, 1'b1, 8'hFF);
		push_enq(16'd256, 1'b0, 8'h01);
		push_enq(16'hFFFF, 1'b1, 8'hA5);
		push_enq(16'd0, 1'b0, 8'h00);
		push_enq(16'd128, 1'b1, 8'h5A);
		push_disp();
		push_disp();
		repeat (15) push_enq(16'($urandom_range(0, 255)), 1'($urandom), 8'($urandom));
		push_enq(16'd7, 1'b0, 8'h33);
		push_enq(16'd300, 1'b1, 8'hCC);

		for (int p = 0; p < N_PHASES; p++) begin
			wait_idle();
			write_reg(dsched_pkg::CFG_POLICY, 17'(ph_pol[p]));
			write_reg(dsched_pkg::CFG_DISK_BLOCKS, 17'(ph_disk[p]));
			@(posedge clk);
			enq_pct = $urandom_range(35, 75);
			repeat (70) begin
				if ($urandom_range(0, 99) < enq_pct)
					push_enq(rand_block(), 1'($urandom), 8'($urandom));
				else
					push_disp();
			end
		end

		// far entry stays queued under SSTF while 270 others pass, so its age wraps
		wait_idle();
		write_reg(dsched_pkg::CFG_POLICY, 17'(dsched_pkg::POL_SSTF));
		write_reg(dsched_pkg::CFG_DISK_BLOCKS, 17'd65536);
		@(posedge clk);
		repeat (17) push_disp();
		push_enq(16'd0, 1'($urandom), 8'($urandom));
		push_disp();
		push_enq(16'hFFFF, 1'($urandom), 8'($urandom));
		repeat (270) begin
			push_enq(16'($urandom_range(0, 255)), 1'($urandom), 8'($urandom));
			push_disp();
		end
		wait_idle();
		write_reg(dsched_pkg::CFG_POLICY, 17'(dsched_pkg::POL_FCFS));
		@(posedge clk);
		repeat (3) push_enq(16'($urandom), 1'($urandom), 8'($urandom));
		repeat (6) push_disp();

		wait_idle();
		repeat (25) @(posedge clk);
		if (errors == 0 && rsp_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
